### design/slco_pkg.sv
// Shared constants, types, codes and a helper function of the subset-lattice chain optimizer.
package slco_pkg;

	localparam int MAX_CELLS = 16;
	localparam int ADDR_W    = MAX_CELLS;
	localparam int DEPTH     = 1 << MAX_CELLS;
	localparam int CELL_W    = 5;
	localparam int MASK_W    = 16;
	localparam int WIDE_W    = 32;
	localparam int COUNT_W   = 32;
	localparam int SUM_W     = 48;

	localparam logic [CELL_W-1:0]  CELLS_RESET = 5'd16;
	localparam logic [SUM_W:0]     SAT_LIMIT   = {{(SUM_W-COUNT_W+1){1'b0}}, {COUNT_W{1'b1}}};

	typedef logic [ADDR_W-1:0] addr_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SAT
	} alu_op_t;

	typedef struct packed {
		alu_op_t            op;
		logic [SUM_W-1:0]   a;
		logic [COUNT_W-1:0] b;
		logic [SUM_W-1:0]   c;
	} alu_req_t;

	typedef struct packed {
		logic [SUM_W-1:0] res;
		logic             gt;
	} alu_rsp_t;

	typedef struct packed {
		logic               we;
		addr_t              waddr;
		logic [COUNT_W-1:0] wdata;
		logic               re;
		addr_t              raddr_a;
		addr_t              raddr_b;
	} cnt_req_t;

	typedef struct packed {
		logic             we;
		addr_t            waddr;
		logic [SUM_W-1:0] wdata;
		logic             re;
		addr_t            raddr;
	} chain_req_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LD_RD,
		ST_LD_WR,
		ST_ZT_RD,
		ST_ZT_WR,
		ST_CH_INIT,
		ST_CH_RD,
		ST_CH_ACC,
		ST_CH_WR,
		ST_GR_CUR,
		ST_GR_ADD,
		ST_GR_RD,
		ST_GR_CMP,
		ST_FIN_RD,
		ST_FIN_OUT
	} state_t;

	// Clamp the programmed cell count into the supported range.
	function automatic logic [CELL_W-1:0] eff_cells(input logic [CELL_W-1:0] cells);
		logic [CELL_W-1:0] n;
		n = cells;
		if (cells == '0) begin
			n = CELL_W'(1);
		end else if (cells > CELL_W'(MAX_CELLS)) begin
			n = CELL_W'(MAX_CELLS);
		end
		return n;
	endfunction

endpackage

### design/slco_ram.sv
// Generic single-write, dual-read RAM with registered read data.
module slco_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule

### design/slco_alu.sv
// Shared adder, saturator and magnitude comparator used by every sequencer pass but the clear.
module slco_alu (
	input  slco_pkg::alu_req_t req,
	output slco_pkg::alu_rsp_t rsp
);
	import slco_pkg::*;

	logic [SUM_W:0]   sum_full;
	logic [SUM_W-1:0] sat_val;

	assign sum_full = {1'b0, req.a} + (SUM_W+1)'(req.b);
	assign sat_val  = (sum_full > SAT_LIMIT) ? SUM_W'(SAT_LIMIT) : sum_full[SUM_W-1:0];

	always_comb begin
		case (req.op)
			ALU_SAT: rsp.res = sat_val;
			ALU_ADD: rsp.res = sum_full[SUM_W-1:0];
			default: rsp.res = sum_full[SUM_W-1:0];
		endcase
		rsp.gt = rsp.res > req.c;
	end

endmodule

### design/slco_seq.sv
// Sequencer of the optimizer: load, transform, chain, greedy and clear passes over the lattice.
module slco_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slco_pkg::CELL_W-1:0]   cells_in_use,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [slco_pkg::MASK_W-1:0]   mask,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [slco_pkg::COUNT_W-1:0]  config_total,
	output logic [slco_pkg::SUM_W-1:0]    best_chain_sum,
	output logic [slco_pkg::SUM_W-1:0]    greedy_sum,
	output logic                          mismatch,
	output slco_pkg::cnt_req_t            cnt_req,
	input  logic [slco_pkg::COUNT_W-1:0]  cnt_rd_a,
	input  logic [slco_pkg::COUNT_W-1:0]  cnt_rd_b,
	output slco_pkg::chain_req_t          chain_req,
	input  logic [slco_pkg::SUM_W-1:0]    chain_rd,
	output slco_pkg::alu_req_t            alu_req,
	input  slco_pkg::alu_rsp_t            alu_rsp
);
	import slco_pkg::*;

	state_t             state_q, state_d;
	logic [CELL_W-1:0]  cells_q;
	logic [CELL_W-1:0]  n_eff;
	logic [CELL_W-1:0]  n_last;
	addr_t              full_set;
	addr_t              bit_oh;
	logic [WIDE_W-1:0]  mask_wide;
	logic               in_ok;

	addr_t              clr_q;
	logic [COUNT_W-1:0] total_q;
	logic               range_q;
	logic               out_valid_q;

	addr_t              addr_q;
	logic               ok_q;
	logic               last_q;
	addr_t              s_q;
	logic [CELL_W-1:0]  bit_q;
	logic [CELL_W-1:0]  t_q;
	logic [SUM_W-1:0]   best_q;
	logic [SUM_W-1:0]   greedy_q;
	logic [COUNT_W-1:0] gain_q;
	addr_t              pick_q;
	addr_t              cur_q;
	logic               first_q;
	logic [COUNT_W-1:0] total_out_q;
	logic [SUM_W-1:0]   best_out_q;
	logic [SUM_W-1:0]   greedy_out_q;
	logic               mismatch_out_q;

	logic               bit_end;
	logic               s_end;
	logic               t_end;
	logic               s_has_bit;
	logic               cur_has_bit;
	logic               take_pick;
	addr_t              pick_now;

	assign n_eff     = eff_cells(cells_q);
	assign n_last    = n_eff - CELL_W'(1);
	assign full_set  = (addr_t'(1) << n_eff) - addr_t'(1);
	assign bit_oh    = addr_t'(1) << bit_q;
	assign mask_wide = WIDE_W'(mask);
	assign in_ok     = (mask_wide >> n_eff) == '0;

	assign bit_end     = bit_q == n_last;
	assign s_end       = s_q == full_set;
	assign t_end       = t_q == n_last;
	assign s_has_bit   = (s_q & bit_oh) != '0;
	assign cur_has_bit = (cur_q & bit_oh) != '0;
	assign take_pick   = (state_q == ST_GR_CMP) && (first_q || alu_rsp.gt);
	assign pick_now    = take_pick ? bit_oh : pick_q;

	assign cfg_ready      = 1'b1;
	assign out_valid      = out_valid_q;
	assign config_total   = total_out_q;
	assign best_chain_sum = best_out_q;
	assign greedy_sum     = greedy_out_q;
	assign mismatch       = mismatch_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		cnt_req   = '0;
		chain_req = '0;
		alu_req   = '0;
		case (state_q)
			ST_CLEAR: begin
				cnt_req.we    = 1'b1;
				cnt_req.waddr = clr_q;
				if (clr_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				alu_req.op = ALU_SAT;
				alu_req.a  = SUM_W'(total_q);
				alu_req.b  = COUNT_W'(1);
				if (in_valid) begin
					state_d = ST_LD_RD;
				end
			end
			ST_LD_RD: begin
				cnt_req.re      = 1'b1;
				cnt_req.raddr_a = addr_q;
				state_d         = ST_LD_WR;
			end
			ST_LD_WR: begin
				alu_req.op    = ALU_SAT;
				alu_req.a     = SUM_W'(cnt_rd_a);
				alu_req.b     = COUNT_W'(1);
				cnt_req.we    = ok_q;
				cnt_req.waddr = addr_q;
				cnt_req.wdata = COUNT_W'(alu_rsp.res);
				state_d       = last_q ? ST_ZT_RD : ST_IDLE;
			end
			ST_ZT_RD: begin
				if (s_has_bit) begin
					cnt_req.re      = 1'b1;
					cnt_req.raddr_a = s_q;
					cnt_req.raddr_b = s_q ^ bit_oh;
					state_d         = ST_ZT_WR;
				end else if (s_end && bit_end) begin
					state_d = ST_CH_INIT;
				end
			end
			ST_ZT_WR: begin
				alu_req.op    = ALU_SAT;
				alu_req.a     = SUM_W'(cnt_rd_a);
				alu_req.b     = cnt_rd_b;
				cnt_req.we    = 1'b1;
				cnt_req.waddr = s_q;
				cnt_req.wdata = COUNT_W'(alu_rsp.res);
				state_d       = (s_end && bit_end) ? ST_CH_INIT : ST_ZT_RD;
			end
			ST_CH_INIT: begin
				chain_req.we    = 1'b1;
				chain_req.waddr = '0;
				state_d         = ST_CH_RD;
			end
			ST_CH_RD: begin
				if (s_has_bit) begin
					cnt_req.re      = 1'b1;
					cnt_req.raddr_a = s_q ^ bit_oh;
					chain_req.re    = 1'b1;
					chain_req.raddr = s_q ^ bit_oh;
					state_d         = ST_CH_ACC;
				end else if (bit_end) begin
					state_d = ST_CH_WR;
				end
			end
			ST_CH_ACC: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = chain_rd;
				alu_req.b  = cnt_rd_a;
				alu_req.c  = best_q;
				state_d    = bit_end ? ST_CH_WR : ST_CH_RD;
			end
			ST_CH_WR: begin
				chain_req.we    = 1'b1;
				chain_req.waddr = s_q;
				chain_req.wdata = best_q;
				state_d         = s_end ? ST_GR_CUR : ST_CH_RD;
			end
			ST_GR_CUR: begin
				cnt_req.re      = 1'b1;
				cnt_req.raddr_a = cur_q;
				state_d         = ST_GR_ADD;
			end
			ST_GR_ADD: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = greedy_q;
				alu_req.b  = cnt_rd_a;
				state_d    = ST_GR_RD;
			end
			ST_GR_RD: begin
				if (!cur_has_bit) begin
					cnt_req.re      = 1'b1;
					cnt_req.raddr_a = cur_q | bit_oh;
					state_d         = ST_GR_CMP;
				end else if (bit_end) begin
					state_d = t_end ? ST_FIN_RD : ST_GR_CUR;
				end
			end
			ST_GR_CMP: begin
				alu_req.op = ALU_ADD;
				alu_req.a  = SUM_W'(cnt_rd_a);
				alu_req.c  = SUM_W'(gain_q);
				if (bit_end) begin
					state_d = t_end ? ST_FIN_RD : ST_GR_CUR;
				end else begin
					state_d = ST_GR_RD;
				end
			end
			ST_FIN_RD: begin
				cnt_req.re      = 1'b1;
				cnt_req.raddr_a = full_set;
				chain_req.re    = 1'b1;
				chain_req.raddr = full_set;
				state_d         = ST_FIN_OUT;
			end
			ST_FIN_OUT: begin
				if (!out_valid_q) begin
					state_d = ST_CLEAR;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Control registers: cell count, clear sweep, run total, error flag and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cells_q     <= CELLS_RESET;
			clr_q       <= '0;
			total_q     <= '0;
			range_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				cells_q <= cells_in_use;
			end
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + addr_t'(1);
			end
			if (state_q == ST_IDLE && in_valid) begin
				total_q <= COUNT_W'(alu_rsp.res);
				if (!in_ok) begin
					range_q <= 1'b1;
				end
			end
			if (state_q == ST_FIN_OUT && !out_valid_q) begin
				out_valid_q <= 1'b1;
				total_q     <= '0;
				range_q     <= 1'b0;
				clr_q       <= '0;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers of the passes.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					addr_q <= addr_t'(mask_wide);
					ok_q   <= in_ok;
					last_q <= last;
				end
				s_q   <= '0;
				bit_q <= '0;
			end
			ST_ZT_RD, ST_ZT_WR: begin
				if (state_q == ST_ZT_WR || !s_has_bit) begin
					if (s_end) begin
						s_q   <= '0;
						bit_q <= bit_q + CELL_W'(1);
					end else begin
						s_q <= s_q + addr_t'(1);
					end
				end
			end
			ST_CH_INIT: begin
				s_q    <= addr_t'(1);
				bit_q  <= '0;
				best_q <= '0;
			end
			ST_CH_RD: begin
				if (!s_has_bit) begin
					bit_q <= bit_q + CELL_W'(1);
				end
			end
			ST_CH_ACC: begin
				if (alu_rsp.gt) begin
					best_q <= alu_rsp.res;
				end
				bit_q <= bit_q + CELL_W'(1);
			end
			ST_CH_WR: begin
				best_q   <= '0;
				bit_q    <= '0;
				s_q      <= s_q + addr_t'(1);
				cur_q    <= '0;
				t_q      <= '0;
				greedy_q <= '0;
			end
			ST_GR_ADD: begin
				greedy_q <= alu_rsp.res;
				first_q  <= 1'b1;
				bit_q    <= '0;
				pick_q   <= '0;
			end
			ST_GR_RD, ST_GR_CMP: begin
				if (take_pick) begin
					gain_q  <= cnt_rd_a;
					pick_q  <= bit_oh;
					first_q <= 1'b0;
				end
				if (state_q == ST_GR_CMP || cur_has_bit) begin
					bit_q <= bit_q + CELL_W'(1);
					if (bit_end) begin
						cur_q <= cur_q | pick_now;
						t_q   <= t_q + CELL_W'(1);
					end
				end
			end
			ST_FIN_OUT: begin
				if (!out_valid_q) begin
					total_out_q    <= total_q;
					best_out_q     <= chain_rd;
					greedy_out_q   <= greedy_q;
					mismatch_out_q <= range_q || (cnt_rd_a != total_q);
				end
			end
			default: begin
			end
		endcase
	end

endmodule

### design/subset_lattice_chain_optimizer.sv
// Top level of the subset-lattice chain optimizer: sequencer, shared ALU and the two lattice RAMs.
// A mask that is not last passes through a read state and a write state; the block is not ready then.
// The last mask then holds the block for the lattice passes: transform, chain and greedy order.
// Load, transform, chain and greedy share the one ALU; the count RAM has a single write port.
// After reset and after each result a clearing pass writes all 2^MAX_CELLS (65536) count entries,
// one a cycle, before the first mask is taken; configuration writes are taken at any time.
module subset_lattice_chain_optimizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [slco_pkg::CELL_W-1:0]   cells_in_use,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [slco_pkg::MASK_W-1:0]   mask,
	input  logic                          last,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [slco_pkg::COUNT_W-1:0]  config_total,
	output logic [slco_pkg::SUM_W-1:0]    best_chain_sum,
	output logic [slco_pkg::SUM_W-1:0]    greedy_sum,
	output logic                          mismatch
);
	import slco_pkg::*;

	cnt_req_t           cnt_req;
	chain_req_t         chain_req;
	alu_req_t           alu_req;
	alu_rsp_t           alu_rsp;
	logic [COUNT_W-1:0] cnt_rd_a;
	logic [COUNT_W-1:0] cnt_rd_b;
	logic [SUM_W-1:0]   chain_rd;

	// The sequencer owns every control register. It steps through the load, transform,
	// chain and greedy passes and finally places one result beat in its output register,
	// which stays there until taken while the clearing pass already runs.
	slco_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cells_in_use   (cells_in_use),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mask           (mask),
		.last           (last),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.config_total   (config_total),
		.best_chain_sum (best_chain_sum),
		.greedy_sum     (greedy_sum),
		.mismatch       (mismatch),
		.cnt_req        (cnt_req),
		.cnt_rd_a       (cnt_rd_a),
		.cnt_rd_b       (cnt_rd_b),
		.chain_req      (chain_req),
		.chain_rd       (chain_rd),
		.alu_req        (alu_req),
		.alu_rsp        (alu_rsp)
	);

	// One adder with optional 32-bit saturation and one compare serve the load, transform, chain and greedy passes.
	slco_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Count table. The transform reads an entry and its partner without the current bit
	// in the same cycle, so both read ports are used.
	slco_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (DEPTH)
	) u_cnt_ram (
		.clk     (clk),
		.we      (cnt_req.we),
		.waddr   (cnt_req.waddr),
		.wdata   (cnt_req.wdata),
		.re      (cnt_req.re),
		.raddr_a (cnt_req.raddr_a),
		.raddr_b (cnt_req.raddr_b),
		.rdata_a (cnt_rd_a),
		.rdata_b (cnt_rd_b)
	);

	// Chain table. Only one read address is ever needed; entry zero is written to zero
	// at the start of each chain pass, and every other entry is written before it is read.
	slco_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_chain_ram (
		.clk     (clk),
		.we      (chain_req.we),
		.waddr   (chain_req.waddr),
		.wdata   (chain_req.wdata),
		.re      (chain_req.re),
		.raddr_a (chain_req.raddr),
		.raddr_b (chain_req.raddr),
		.rdata_a (chain_rd),
		.rdata_b ()
	);

	// Every accepted mask keeps the block busy for at least the following cycle.
	a_busy_after_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken again right after a mask beat");

	// A new result appears only as the clearing pass starts, so input is closed then.
	a_result_closes_input: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !in_ready)
		else $error("result raised while input is open");

	// A taken result beat is never followed at once by another one.
	a_no_result_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) |=> !out_valid)
		else $error("second result beat directly after a taken one");

endmodule
